// ===== sv/smks_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smks_pkg
// Shared types and constants of the analog key-sensor matrix scanner.
// ----------------------------------------------------------------------------
package smks_pkg;

    localparam int LINES         = 4;
    localparam int CHANNELS      = 4;
    localparam int KEYS          = 9;
    localparam int HISTORY_DEPTH = 3;
    localparam int SENSORS       = LINES * CHANNELS;

    localparam int SENSOR_W = $clog2(SENSORS);
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 14;
    localparam int THR_W    = 10;
    localparam int BIND_W   = 4;
    localparam int CODE_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int MUL_W    = 16;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SCALED_W = SAMPLE_W + 11;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    // Unity of the ratio scale.
    localparam int RATIO_ONE = 1024;

    // Truncating divide by three: floor(sum * 43691 / 2^17) is exact for any
    // sum of three twelve-bit samples.
    localparam logic [MUL_W-1:0] DIV3_RECIP = 16'd43691;
    localparam int               DIV3_SHIFT = 17;

    localparam logic [39:0]       THR_RESET        = 40'd806093568750;
    localparam logic [63:0]       BIND_RESET       = 64'd5139530022764496725;
    localparam logic [39:0]       CODES_LOW_RESET  = 40'd43102508821;
    localparam logic [31:0]       CODES_HIGH_RESET = 32'd285546763;
    localparam logic [SAMPLE_W-1:0] OFFSET_RESET   = 12'd4000;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_CAPTURE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLDS_A  = 3'd0,
        REG_THRESHOLDS_B  = 3'd1,
        REG_THRESHOLDS_C  = 3'd2,
        REG_THRESHOLDS_D  = 3'd3,
        REG_SENSOR_TO_KEY = 3'd4,
        REG_KEY_CODES_LOW = 3'd5,
        REG_KEY_CODES_HIGH = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV3,
        ST_SCALE,
        ST_TEST,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== sv/smks_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smks_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module smks_mul
    import smks_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MUL_W-1:0]  a,
    input  wire logic [MUL_W-1:0]  b,
    output logic      [PROD_W-1:0] p
);

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== sv/sensor_matrix_key_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_matrix_key_scanner
// Sample history, offset capture and key report scan of a 4x4 sensor matrix.
// ----------------------------------------------------------------------------
// A sample or capture item is taken while idle and produces nothing. A scan
// item walks the sixteen sensors in turn, each through the sum, divide, scale
// and test states, using one shared multiplier: the three-sample sum is
// divided by three by reciprocal multiplication, then (threshold + 1025) *
// average is compared against offset * 1024, which is the same test as
// threshold < floor(offset*1024/avg) - 1024. After the walk the nine report
// items (slots 0 to 8, tlast on slot 8) are loaded into the output register,
// one per cycle while the downstream side is ready. The input side is ready
// again once the final slot sits in the output register.
module sensor_matrix_key_scanner
    import smks_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,  // cmd[1:0], line[3:2], channel[5:4], sample[17:6]
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [15:0]          m_tdata,  // slot[3:0], key_code[11:4]
    output logic                      m_tlast
);

    // configuration registers
    logic [39:0] thresholds_a_reg;
    logic [39:0] thresholds_b_reg;
    logic [39:0] thresholds_c_reg;
    logic [39:0] thresholds_d_reg;
    logic [63:0] sensor_to_key_reg;
    logic [39:0] key_codes_low_reg;
    logic [31:0] key_codes_high_reg;

    // per-sensor state: newest sample in the low bits
    logic [HISTORY_DEPTH*SAMPLE_W-1:0] hist_reg [SENSORS];
    logic [SAMPLE_W-1:0]               offset_reg [SENSORS];

    state_t                state_reg, state_next;
    logic [SENSOR_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [KEYS-1:0]       pressed_reg, pressed_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [CODE_W-1:0]     out_code_reg, out_code_next;
    logic                  out_last_reg, out_last_next;

    logic                  hist_we;
    logic                  capture_en;
    logic [SENSOR_W-1:0]   wr_idx;

    logic [1:0]            in_cmd;
    logic [1:0]            in_line;
    logic [1:0]            in_channel;
    logic [SAMPLE_W-1:0]   in_sample;
    logic                  in_accept;
    logic                  in_matrix;

    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [PROD_W-1:0]     prod;

    logic [4*40-1:0]       thr_all;
    logic [THR_W-1:0]      thr_sel;
    logic [BIND_W-1:0]     key_sel;
    logic [72-1:0]         codes_all;
    logic [SAMPLE_W-1:0]   avg;
    logic [HISTORY_DEPTH*SAMPLE_W-1:0] row;
    logic [SCALED_W-1:0]   scaled_offset;
    logic                  sensor_on;
    logic                  out_load;

    assign in_cmd     = s_tdata[1:0];
    assign in_line    = s_tdata[3:2];
    assign in_channel = s_tdata[5:4];
    assign in_sample  = s_tdata[17:6];
    assign in_accept  = s_tvalid && s_tready;
    assign in_matrix  = (32'(in_line) < LINES) && (32'(in_channel) < CHANNELS);
    assign wr_idx     = SENSOR_W'(32'(in_line) * CHANNELS + 32'(in_channel));

    assign thr_all   = {thresholds_d_reg, thresholds_c_reg, thresholds_b_reg, thresholds_a_reg};
    assign thr_sel   = thr_all[idx_reg*THR_W +: THR_W];
    assign key_sel   = sensor_to_key_reg[idx_reg*BIND_W +: BIND_W];
    assign codes_all = {key_codes_high_reg, key_codes_low_reg};
    assign row       = hist_reg[idx_reg];
    assign avg       = prod[DIV3_SHIFT +: SAMPLE_W];

    // offset * 1024 >= (thr + 1025) * avg  <=>  floor(offset*1024/avg) - 1024 > thr.
    // A zero average leaves a zero product, so that sensor is always on.
    assign scaled_offset = SCALED_W'({offset_reg[idx_reg], 10'b0});
    assign sensor_on     = {1'b0, scaled_offset} >= prod[SCALED_W:0];

    smks_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        pressed_next   = pressed_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_slot_next  = out_slot_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        hist_we        = 1'b0;
        capture_en     = 1'b0;
        s_tready       = 1'b0;
        out_load       = 1'b0;
        mul_a          = MUL_W'(sum_reg);
        mul_b          = DIV3_RECIP;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_accept)
                begin
                    unique case (in_cmd)
                        CMD_SAMPLE:  hist_we = in_matrix;
                        CMD_CAPTURE: capture_en = 1'b1;
                        CMD_SCAN:
                        begin
                            idx_next     = '0;
                            pressed_next = '0;
                            state_next   = ST_SUM;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SUM:
            begin
                sum_next = SUM_W'(row[SAMPLE_W-1:0]) + SUM_W'(row[2*SAMPLE_W-1:SAMPLE_W])
                         + SUM_W'(row[3*SAMPLE_W-1:2*SAMPLE_W]);
                state_next = ST_DIV3;
            end
            ST_DIV3:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_a      = MUL_W'(avg);
                mul_b      = MUL_W'(thr_sel) + MUL_W'(RATIO_ONE + 1);
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                for (int k = 0; k < KEYS; k++)
                begin
                    if (sensor_on && (32'(key_sel) == k))
                        pressed_next[k] = 1'b1;
                end
                idx_next = idx_reg + SENSOR_W'(1);
                if (idx_reg == SENSOR_W'(SENSORS - 1))
                begin
                    slot_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_SUM;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || m_tready;
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = slot_reg;
                    out_code_next  = pressed_reg[slot_reg] ? codes_all[slot_reg*CODE_W +: CODE_W]
                                                           : '0;
                    out_last_next  = (slot_reg == SLOT_W'(KEYS - 1));
                    slot_next      = slot_reg + SLOT_W'(1);
                    if (slot_reg == SLOT_W'(KEYS - 1))
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            slot_reg      <= '0;
            pressed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            pressed_reg   <= pressed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_slot_reg <= out_slot_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    // Sample history shifts in place; a capture copies every newest sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                hist_reg[i]   <= '0;
                offset_reg[i] <= OFFSET_RESET;
            end
        end
        else
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                if (hist_we && (wr_idx == SENSOR_W'(i)))
                    hist_reg[i] <= {hist_reg[i][(HISTORY_DEPTH-1)*SAMPLE_W-1:0], in_sample};
                if (capture_en)
                    offset_reg[i] <= hist_reg[i][SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_a_reg   <= THR_RESET;
            thresholds_b_reg   <= THR_RESET;
            thresholds_c_reg   <= THR_RESET;
            thresholds_d_reg   <= THR_RESET;
            sensor_to_key_reg  <= BIND_RESET;
            key_codes_low_reg  <= CODES_LOW_RESET;
            key_codes_high_reg <= CODES_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLDS_A:   thresholds_a_reg   <= cfg_data[39:0];
                REG_THRESHOLDS_B:   thresholds_b_reg   <= cfg_data[39:0];
                REG_THRESHOLDS_C:   thresholds_c_reg   <= cfg_data[39:0];
                REG_THRESHOLDS_D:   thresholds_d_reg   <= cfg_data[39:0];
                REG_SENSOR_TO_KEY:  sensor_to_key_reg  <= cfg_data;
                REG_KEY_CODES_LOW:  key_codes_low_reg  <= cfg_data[39:0];
                REG_KEY_CODES_HIGH: key_codes_high_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_code_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

    // A scan item starts the sensor walk at the first sensor.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_cmd == CMD_SCAN)) |=> (state_reg == ST_SUM && idx_reg == '0))
        else $error("scan did not start at sensor zero");

    // The last sensor test always hands over to the report phase.
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && idx_reg == SENSOR_W'(SENSORS - 1)) |=> (state_reg == ST_EMIT))
        else $error("sensor walk did not end in report phase");

    // Leaving the report phase means the final slot has just been loaded.
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> (m_tvalid && m_tlast))
        else $error("report ended without the final slot");

    // tlast marks the final slot and no other.
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == SLOT_W'(KEYS - 1))))
        else $error("tlast does not match the final slot");

endmodule
`default_nettype wire
